### rtl/vmmr_pkg.sv
// Shared types and constants for the voltmeter min/max reporter.
`timescale 1ns / 1ps
`default_nettype none

package vmmr_pkg;

  // Batch geometry; the count is a power of two so the average is a shift.
  localparam int SAMPLE_COUNT = 8;
  localparam int SAMPLE_SHIFT = $clog2(SAMPLE_COUNT);
  localparam int SAMPLE_W     = 10;
  localparam int SUM_W        = SAMPLE_W + SAMPLE_SHIFT;
  localparam int VOLT_W       = 6;
  localparam int BYTE_W       = 8;
  localparam int SCALED_W     = 16;

  // Scaling to tenths of a volt: (avg * 33 + 511) / 1023.
  localparam logic [SCALED_W-1:0] SCALE_MUL = 16'd33;
  localparam logic [SCALED_W-1:0] SCALE_RND = 16'd511;
  localparam logic [10:0]         SCALE_DIV = 11'd1023;

  localparam logic [VOLT_W-1:0] MIN_RESET = 6'd35;
  localparam logic [VOLT_W-1:0] MAX_RESET = 6'd0;

  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] ASCII_L_UP  = 8'h4C;
  localparam logic [BYTE_W-1:0] ASCII_L_LO  = 8'h6C;

  // Reply beat positions.
  localparam logic [2:0] RPT_IDLE   = 3'd0;
  localparam logic [2:0] RPT_MIN_T  = 3'd1;
  localparam logic [2:0] RPT_MIN_O  = 3'd2;
  localparam logic [2:0] RPT_SPACE  = 3'd3;
  localparam logic [2:0] RPT_MAX_T  = 3'd4;
  localparam logic [2:0] RPT_MAX_O  = 3'd5;

  typedef enum logic {
    ACT_BATCH = 1'b0,
    ACT_RX    = 1'b1
  } action_t;

  typedef enum logic {
    KIND_VOLT = 1'b0,
    KIND_TX   = 1'b1
  } kind_t;

  typedef struct packed {
    action_t             action;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic [BYTE_W-1:0]   rx_byte;
  } item_t;

  typedef struct packed {
    kind_t             kind;
    logic [VOLT_W-1:0] voltage;
    logic [BYTE_W-1:0] tx_byte;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

### rtl/voltmeter_min_max_reporter_core.sv
// Top level of the voltmeter min/max reporter: input stage, scaler, min/max and reply sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (item_valid/item_ready/item) carries either a batch of eight
//   10-bit converter samples (action = batch) or one received serial byte.
//   Output channel (res_valid/res_ready/res) carries voltage updates and the
//   ASCII bytes of a min/max report; last marks the final beat of an item.
//   A batch gives one voltage beat in tenths of a volt (0..33) and updates the
//   running minimum and maximum. An 'L' or 'l' byte gives six beats:
//   space, min tens, min ones, space, max tens, max ones. Other bytes give none.
//   Path: an accepted beat is registered in the input register, then in the
//   result register, from which it is offered on the output channel.
//   Throughput: one batch per cycle while res_ready stays high; a report takes
//   six output beats, and the beat behind it waits in the input register until
//   the last reply beat has loaded.
//   Reset: rst (synchronous, active high) empties both stages, clears the
//   reply counter, and sets the minimum to 35 and the maximum to 0.
//   Stall: while res_ready is low the result beat holds; the input register
//   still takes one more beat, then item_ready drops.
module voltmeter_min_max_reporter_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output      logic            item_ready,
  input  wire vmmr_pkg::item_t item,
  output      logic            res_valid,
  input  wire logic            res_ready,
  output      vmmr_pkg::result_t res
);

  // Input stage: hold the sample sum rather than the raw samples.
  logic                           in_vld;
  vmmr_pkg::action_t              in_action;
  logic [vmmr_pkg::SUM_W-1:0]     in_sum;
  logic [vmmr_pkg::BYTE_W-1:0]    in_rx;
  logic [vmmr_pkg::SUM_W-1:0]     sum_next;

  // Running extremes and reply sequencer.
  logic [vmmr_pkg::VOLT_W-1:0]    min_volts;
  logic [vmmr_pkg::VOLT_W-1:0]    max_volts;
  logic [2:0]                     rpt_cnt;

  // Result register.
  logic                           out_vld;
  vmmr_pkg::result_t              out_beat;

  logic                           load;
  logic                           take;
  logic                           is_batch;
  logic                           is_report;

  logic [vmmr_pkg::SAMPLE_W-1:0]  avg;
  logic [vmmr_pkg::SCALED_W-1:0]  scaled;
  logic [vmmr_pkg::VOLT_W-1:0]    quot_est;
  logic [10:0]                    rem_est;
  logic [vmmr_pkg::VOLT_W-1:0]    volts;

  logic [15:0]                    min_digits;
  logic [15:0]                    max_digits;
  logic [vmmr_pkg::BYTE_W-1:0]    rpt_byte;

  // Split a value into two ASCII decimal digits {tens, ones}.
  function automatic logic [15:0] to_digits(input logic [vmmr_pkg::VOLT_W-1:0] v);
    logic [3:0]                  tens;
    logic [vmmr_pkg::VOLT_W-1:0] ones;
    tens = 4'd0;
    ones = v;
    if (v >= 6'd60) begin
      tens = 4'd6;
      ones = v - 6'd60;
    end else if (v >= 6'd50) begin
      tens = 4'd5;
      ones = v - 6'd50;
    end else if (v >= 6'd40) begin
      tens = 4'd4;
      ones = v - 6'd40;
    end else if (v >= 6'd30) begin
      tens = 4'd3;
      ones = v - 6'd30;
    end else if (v >= 6'd20) begin
      tens = 4'd2;
      ones = v - 6'd20;
    end else if (v >= 6'd10) begin
      tens = 4'd1;
      ones = v - 6'd10;
    end
    return {vmmr_pkg::ASCII_ZERO + {4'd0, tens},
            vmmr_pkg::ASCII_ZERO + {4'd0, ones[3:0]}};
  endfunction

  // Sum the batch on the way into the input register.
  always_comb begin
    logic [vmmr_pkg::SAMPLE_W-1:0] smp [8];
    smp[0] = item.sample_0;
    smp[1] = item.sample_1;
    smp[2] = item.sample_2;
    smp[3] = item.sample_3;
    smp[4] = item.sample_4;
    smp[5] = item.sample_5;
    smp[6] = item.sample_6;
    smp[7] = item.sample_7;
    sum_next = '0;
    for (int i = 0; i < vmmr_pkg::SAMPLE_COUNT; i++) begin
      sum_next = sum_next + {{vmmr_pkg::SAMPLE_SHIFT{1'b0}}, smp[i]};
    end
  end

  // Advance the result register when it is empty or being drained.
  assign load       = !out_vld || res_ready;
  // Consume the held beat only when no report is still streaming out.
  assign take       = in_vld && load && (rpt_cnt == vmmr_pkg::RPT_IDLE);
  assign item_ready = !in_vld || take;

  assign is_batch  = (in_action == vmmr_pkg::ACT_BATCH);
  assign is_report = (in_action == vmmr_pkg::ACT_RX) &&
                     ((in_rx == vmmr_pkg::ASCII_L_UP) || (in_rx == vmmr_pkg::ASCII_L_LO));

  // Scale: avg*33 + 511, then divide by 1023 via x>>10 and one correction.
  assign avg      = in_sum[vmmr_pkg::SAMPLE_SHIFT +: vmmr_pkg::SAMPLE_W];
  assign scaled   = {{(vmmr_pkg::SCALED_W - vmmr_pkg::SAMPLE_W){1'b0}}, avg}
                    * vmmr_pkg::SCALE_MUL + vmmr_pkg::SCALE_RND;
  assign quot_est = scaled[15:10];
  assign rem_est  = {1'b0, scaled[9:0]} + {5'd0, quot_est};
  assign volts    = quot_est + {5'd0, (rem_est >= vmmr_pkg::SCALE_DIV)};

  // Extremes do not move while a report streams, so read them directly.
  assign min_digits = to_digits(min_volts);
  assign max_digits = to_digits(max_volts);

  always_comb begin
    case (rpt_cnt)
      vmmr_pkg::RPT_MIN_T: rpt_byte = min_digits[15:8];
      vmmr_pkg::RPT_MIN_O: rpt_byte = min_digits[7:0];
      vmmr_pkg::RPT_SPACE: rpt_byte = vmmr_pkg::ASCII_SPACE;
      vmmr_pkg::RPT_MAX_T: rpt_byte = max_digits[15:8];
      vmmr_pkg::RPT_MAX_O: rpt_byte = max_digits[7:0];
      default:             rpt_byte = vmmr_pkg::ASCII_SPACE;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item_ready) begin
      in_vld <= item_valid;
    end
    if (item_ready && item_valid) begin
      in_action <= item.action;
      in_sum    <= sum_next;
      in_rx     <= item.rx_byte;
    end
  end

  // Result register, extremes and reply counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld   <= 1'b0;
      rpt_cnt   <= vmmr_pkg::RPT_IDLE;
      min_volts <= vmmr_pkg::MIN_RESET;
      max_volts <= vmmr_pkg::MAX_RESET;
    end else if (load) begin
      if (rpt_cnt != vmmr_pkg::RPT_IDLE) begin
        out_vld          <= 1'b1;
        out_beat.kind    <= vmmr_pkg::KIND_TX;
        out_beat.voltage <= '0;
        out_beat.tx_byte <= rpt_byte;
        out_beat.last    <= (rpt_cnt == vmmr_pkg::RPT_MAX_O);
        rpt_cnt          <= (rpt_cnt == vmmr_pkg::RPT_MAX_O) ? vmmr_pkg::RPT_IDLE
                                                             : rpt_cnt + 3'd1;
      end else if (take && is_batch) begin
        out_vld          <= 1'b1;
        out_beat.kind    <= vmmr_pkg::KIND_VOLT;
        out_beat.voltage <= volts;
        out_beat.tx_byte <= '0;
        out_beat.last    <= 1'b1;
        if (volts < min_volts) begin
          min_volts <= volts;
        end
        if (volts > max_volts) begin
          max_volts <= volts;
        end
      end else if (take && is_report) begin
        // Leading space now; the sequencer emits the other five beats.
        out_vld          <= 1'b1;
        out_beat.kind    <= vmmr_pkg::KIND_TX;
        out_beat.voltage <= '0;
        out_beat.tx_byte <= vmmr_pkg::ASCII_SPACE;
        out_beat.last    <= 1'b0;
        rpt_cnt          <= vmmr_pkg::RPT_MIN_T;
      end else begin
        // Drop other serial bytes; nothing to show.
        out_vld <= 1'b0;
      end
    end
  end

  assign res_valid = out_vld;
  assign res       = out_beat;

  // A report in flight always has a beat on the output.
  a_rpt_has_beat: assert property (@(posedge clk) disable iff (rst)
    (rpt_cnt != vmmr_pkg::RPT_IDLE) |-> out_vld)
    else $error("reply counter active without an output beat");

  // The reply counter stays within the six-beat report.
  a_rpt_range: assert property (@(posedge clk) disable iff (rst)
    rpt_cnt <= vmmr_pkg::RPT_MAX_O)
    else $error("reply counter out of range");

  // The maximum stays within the scaled range; the minimum stays at or below its reset value.
  a_extremes: assert property (@(posedge clk) disable iff (rst)
    (min_volts <= vmmr_pkg::MIN_RESET) && (max_volts <= 6'd33))
    else $error("running extreme out of range");

  // Extremes hold while a report streams out.
  a_hold_extremes: assert property (@(posedge clk) disable iff (rst)
    (rpt_cnt != vmmr_pkg::RPT_IDLE) |=> ($stable(min_volts) && $stable(max_volts)))
    else $error("extremes changed during a report");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the voltmeter min/max reporter core.
`timescale 1ns / 1ps

module testbench;

  // Scaling of the batch average to tenths of a volt, and report characters.
  localparam int unsigned MUL_TENTHS = 33;
  localparam int unsigned RND_TENTHS = 511;
  localparam int unsigned FULL_SCALE = 1023;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_L_UP  = 8'h4C;
  localparam logic [7:0] CHR_L_LO  = 8'h6C;
  localparam logic [5:0] LOW_AT_RESET  = 6'd35;
  localparam logic [5:0] HIGH_AT_RESET = 6'd0;

  // Run shape.
  localparam int PLAN_ROWS       = 23;
  localparam int RANDOM_ITEMS    = 100;
  localparam int IDLE_PCT        = 11;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 200000;

  // One row of the directed plan; typed rows carry their answer inline.
  typedef struct {
    vmmr_pkg::item_t beat;
    bit              typed;
    logic [5:0]      volts;
    logic [5:0]      lo;
    logic [5:0]      hi;
  } plan_row_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  vmmr_pkg::item_t   item       = '0;
  logic              res_valid;
  logic              res_ready  = 1'b0;
  vmmr_pkg::result_t res;

  // Running min/max as the block should hold them, and the beats still owed.
  logic [5:0]        low_mark  = LOW_AT_RESET;
  logic [5:0]        high_mark = HIGH_AT_RESET;
  vmmr_pkg::result_t owed_beats[$];
  plan_row_t         plan[PLAN_ROWS];
  int                mismatches    = 0;
  int                cycle_count   = 0;
  bit                hold_off_req  = 1'b0;

  voltmeter_min_max_reporter_core dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Average the batch with truncation, then scale with rounding to tenths.
  function automatic logic [5:0] tenths_of_batch(input vmmr_pkg::item_t b);
    int unsigned total;
    int unsigned mean;
    total = b.sample_0 + b.sample_1 + b.sample_2 + b.sample_3
          + b.sample_4 + b.sample_5 + b.sample_6 + b.sample_7;
    mean  = total / vmmr_pkg::SAMPLE_COUNT;
    return 6'((mean * MUL_TENTHS + RND_TENTHS) / FULL_SCALE);
  endfunction

  function automatic vmmr_pkg::result_t beat_of(input vmmr_pkg::kind_t k,
                                                input logic [5:0] v,
                                                input logic [7:0] c, input logic l);
    vmmr_pkg::result_t r;
    r.kind    = k;
    r.voltage = v;
    r.tx_byte = c;
    r.last    = l;
    return r;
  endfunction

  // Advance the min/max for an accepted beat and queue the beats it owes.
  // A typed row overrides the computed answer with the one written in the plan.
  function automatic int owe_beats(input vmmr_pkg::item_t b, input bit typed,
                                   input logic [5:0] volts, input logic [5:0] lo,
                                   input logic [5:0] hi);
    logic [5:0] v;
    logic [5:0] rep_lo;
    logic [5:0] rep_hi;
    if (b.action == vmmr_pkg::ACT_BATCH) begin
      v = tenths_of_batch(b);
      if (v < low_mark) low_mark = v;
      if (v > high_mark) high_mark = v;
      owed_beats.push_back(beat_of(vmmr_pkg::KIND_VOLT, typed ? volts : v, 8'h00, 1'b1));
      return 1;
    end
    // Any byte other than an upper or lower L is dropped without a reply.
    if (b.rx_byte != CHR_L_UP && b.rx_byte != CHR_L_LO) return 0;
    rep_lo = typed ? lo : low_mark;
    rep_hi = typed ? hi : high_mark;
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_SPACE, 1'b0));
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_ZERO + rep_lo / 6'd10, 1'b0));
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_ZERO + rep_lo % 6'd10, 1'b0));
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_SPACE, 1'b0));
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_ZERO + rep_hi / 6'd10, 1'b0));
    owed_beats.push_back(beat_of(vmmr_pkg::KIND_TX, 6'd0, CHR_ZERO + rep_hi % 6'd10, 1'b1));
    return 6;
  endfunction

  function automatic plan_row_t row_of(input vmmr_pkg::action_t a, input logic [79:0] smp,
                                       input logic [7:0] rx, input bit typed,
                                       input logic [5:0] v, input logic [5:0] lo,
                                       input logic [5:0] hi);
    plan_row_t r;
    r.beat  = {a, smp, rx};
    r.typed = typed;
    r.volts = v;
    r.lo    = lo;
    r.hi    = hi;
    return r;
  endfunction

  // Mostly batches and report requests; the rest are stray serial bytes.
  // Batch samples cluster around a random center or span the full range.
  function automatic vmmr_pkg::item_t random_item();
    vmmr_pkg::item_t b;
    logic [9:0]      s[8];
    int unsigned     center;
    int unsigned     spread;
    int unsigned     lo;
    int unsigned     hi;
    center = $urandom_range(1023);
    spread = ($urandom_range(3) == 0) ? 1023 : $urandom_range(64);
    lo     = (center > spread) ? center - spread : 0;
    hi     = (center + spread > 1023) ? 1023 : center + spread;
    for (int i = 0; i < 8; i++) s[i] = 10'($urandom_range(hi, lo));
    b.action   = ($urandom_range(99) < 65) ? vmmr_pkg::ACT_BATCH : vmmr_pkg::ACT_RX;
    b.sample_0 = s[0];
    b.sample_1 = s[1];
    b.sample_2 = s[2];
    b.sample_3 = s[3];
    b.sample_4 = s[4];
    b.sample_5 = s[5];
    b.sample_6 = s[6];
    b.sample_7 = s[7];
    if (b.action == vmmr_pkg::ACT_RX && $urandom_range(99) < 80) begin
      b.rx_byte = $urandom_range(1) ? CHR_L_UP : CHR_L_LO;
    end else begin
      b.rx_byte = 8'($urandom);
    end
    return b;
  endfunction

  // Present one beat at the falling edge, with random idle cycles ahead of it,
  // and hold it until the rising edge that accepts it.
  task automatic offer(input vmmr_pkg::item_t b, input bit may_idle);
    @(negedge clk);
    while (may_idle && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Stimulus: reset, the directed plan, then the random stream.
  initial begin : stimulus
    vmmr_pkg::item_t b;
    int              n;
    bit              hold_asked;
    hold_asked = 1'b0;

    // Report before any batch: the minimum still reads 35, the maximum 0.
    plan[0]  = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_UP, 1'b1, '0, LOW_AT_RESET, HIGH_AT_RESET);
    plan[1]  = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_LO, 1'b1, '0, LOW_AT_RESET, HIGH_AT_RESET);
    // Stray bytes, including L with the top bit set, give nothing.
    plan[2]  = row_of(vmmr_pkg::ACT_RX, '0, 8'h4B, 1'b0, '0, '0, '0);
    plan[3]  = row_of(vmmr_pkg::ACT_RX, '0, 8'h00, 1'b0, '0, '0, '0);
    plan[4]  = row_of(vmmr_pkg::ACT_RX, {80{1'b1}}, 8'hFF, 1'b0, '0, '0, '0);
    plan[5]  = row_of(vmmr_pkg::ACT_RX, '0, 8'hCC, 1'b0, '0, '0, '0);
    // Samples ride along on a serial byte and must be ignored.
    plan[6]  = row_of(vmmr_pkg::ACT_RX, {80{1'b1}}, CHR_L_UP, 1'b1, '0, LOW_AT_RESET,
                      HIGH_AT_RESET);
    // Walk the min/max through middle values, with reports in between.
    plan[7]  = row_of(vmmr_pkg::ACT_BATCH, {8{10'd512}}, 8'h00, 1'b0, '0, '0, '0);
    plan[8]  = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_UP, 1'b0, '0, '0, '0);
    plan[9]  = row_of(vmmr_pkg::ACT_BATCH, {8{10'd800}}, CHR_L_UP, 1'b0, '0, '0, '0);
    plan[10] = row_of(vmmr_pkg::ACT_BATCH, {8{10'd200}}, 8'h00, 1'b0, '0, '0, '0);
    plan[11] = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_LO, 1'b0, '0, '0, '0);
    // Lowest average that rounds up to one tenth.
    plan[12] = row_of(vmmr_pkg::ACT_BATCH, {8{10'd16}}, 8'h00, 1'b1, 6'd1, '0, '0);
    plan[13] = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_UP, 1'b0, '0, '0, '0);
    // Full scale, then a report of min 01 and max 33.
    plan[14] = row_of(vmmr_pkg::ACT_BATCH, {8{10'd1023}}, 8'hFF, 1'b1, 6'd33, '0, '0);
    plan[15] = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_UP, 1'b1, '0, 6'd1, 6'd33);
    plan[16] = row_of(vmmr_pkg::ACT_BATCH, {10'd1023, {7{10'd0}}}, 8'h00, 1'b0, '0, '0, '0);
    plan[17] = row_of(vmmr_pkg::ACT_BATCH, {4{10'h2AA, 10'h155}}, 8'h55, 1'b0, '0, '0, '0);
    plan[18] = row_of(vmmr_pkg::ACT_BATCH, {4{10'h155, 10'h2AA}}, 8'hAA, 1'b0, '0, '0, '0);
    // Sum of 127 truncates to an average of 15, which rounds down to zero.
    plan[19] = row_of(vmmr_pkg::ACT_BATCH, {{7{10'd16}}, 10'd15}, 8'h00, 1'b1, 6'd0, '0, '0);
    plan[20] = row_of(vmmr_pkg::ACT_BATCH, {8{10'd0}}, 8'hFF, 1'b1, 6'd0, '0, '0);
    plan[21] = row_of(vmmr_pkg::ACT_RX, '0, CHR_L_LO, 1'b1, '0, 6'd0, 6'd33);
    plan[22] = row_of(vmmr_pkg::ACT_BATCH, {8{10'd15}}, 8'h00, 1'b1, 6'd0, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      offer(plan[i].beat, 1'b1);
      void'(owe_beats(plan[i].beat, plan[i].typed, plan[i].volts, plan[i].lo,
                      plan[i].hi));
    end

    // Random stream; only beats that owe a reply count toward its length.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      b = random_item();
      // Ask the receiver to hold off while beats keep coming, to fill the block.
      if (n == 25 && !hold_asked) begin
        hold_off_req = 1'b1;
        hold_asked   = 1'b1;
      end
      // Pause while the count stands at 90, with valid dropped, until every owed beat is back.
      if (n == 90) begin
        @(negedge clk);
        item_valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge clk);
      end
      offer(b, !(n >= 45 && n < 75));
      if (owe_beats(b, 1'b0, '0, '0, '0) != 0) n++;
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, one quiet stretch, and one long hold-off on request.
  initial begin : sink
    int hold_left;
    int tick;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (tick >= 200 && tick < 450) begin
        res_ready <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each accepted result beat with the oldest owed beat.
  always @(posedge clk) begin : check_beat
    vmmr_pkg::result_t want;
    if (!rst && res_valid && res_ready) begin
      if (owed_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d/%0d",
                 $time, res.kind, res.voltage, res.tx_byte, res.last);
        mismatches++;
      end else begin
        want = owed_beats.pop_front();
        compare_field("kind", want.kind, res.kind);
        compare_field("voltage", want.voltage, res.voltage);
        compare_field("tx_byte", want.tx_byte, res.tx_byte);
        compare_field("last", want.last, res.last);
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule
